### rtl/cshm_pkg.sv
// ----------------------------------------------------------------------------
// cshm_pkg
// Types and constants shared by the C-SCAN head movement evaluator.
// ----------------------------------------------------------------------------
package cshm_pkg;

   localparam int MAX_REQUESTS_DEF = 64;
   localparam int TRACK_BITS_DEF   = 12;

   localparam int TOTAL_MAX = 16383;
   localparam int COUNT_MAX = 127;
   localparam int AVG_MAX   = 4194303;

   typedef enum logic {
      CSR_HEAD_POSITION = 1'b0,
      CSR_DIRECTION_UP  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [11:0] track;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [13:0] total_movement;
      logic [6:0]  request_count;
      logic [21:0] average_q8;
      logic        status;
   } rsp_type;

endpackage

### rtl/cscan_head_movement.sv
// ----------------------------------------------------------------------------
// cscan_head_movement
// Collects track requests, then sums C-SCAN head movement and its Q8 average.
// ----------------------------------------------------------------------------
// Requests load one per cycle while busy is low; running min, max and nearest
// tracks around the head are kept on the fly, so no sort pass is needed.
// A transaction with last set keeps busy high through the summing steps and the
// restoring-division steps, whose subtractor is separate from the summing one;
// the result strobe rises as busy falls. The receiver cannot stall.
// Synchronous reset clears count and flags, zeroes the head and sets direction up.
module cscan_head_movement #(
   parameter int MAX_REQUESTS = cshm_pkg::MAX_REQUESTS_DEF,
   parameter int TRACK_BITS   = cshm_pkg::TRACK_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cshm_pkg::req_type req_data,
   output logic              rsp_valid,
   output cshm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [11:0]       csr_wdata
);
   import cshm_pkg::*;

   localparam int T  = TRACK_BITS;
   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int TW = T + 2;
   localparam int DW = TW + 8;
   localparam int KW = $clog2(DW + 1);

   typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV} state_type;

   state_type      state_ff, state_in;
   logic [1:0]     step_ff, step_in;
   logic [KW-1:0]  kcnt_ff, kcnt_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic [T-1:0]   head_ff, head_in;
   logic           up_ff, up_in;
   logic [T-1:0]   min_ff, min_in, max_ff, max_in, lo_ff, lo_in, hi_ff, hi_in;
   logic           lo_v_ff, lo_v_in, hi_v_ff, hi_v_in, eq_ff, eq_in;
   logic [TW-1:0]  acc_ff, acc_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [CW:0]    rem_ff, rem_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [T-1:0]   trk;
   logic           take, keep, first;
   logic           side_hit;
   logic [T-1:0]   op_a, op_b;
   logic [TW-1:0]  diff;
   logic [CW:0]    rem_sh;
   logic [CW:0]    rem_sub;

   assign trk   = T'(req_data.track);
   assign take  = start && (state_ff == S_IDLE);
   assign keep  = cnt_ff != CW'(MAX_REQUESTS);
   assign first = cnt_ff == '0;
   assign side_hit = up_ff ? (hi_v_ff || eq_ff) : (lo_v_ff || eq_ff);

   always_comb begin
      op_a = max_ff;
      op_b = min_ff;
      case (step_ff)
         2'd0: begin
            if (side_hit) begin
               op_a = up_ff ? max_ff : head_ff;
               op_b = up_ff ? head_ff : min_ff;
            end
         end
         2'd2: begin
            if (!side_hit) begin
               op_a = '0;
               op_b = '0;
            end else if (up_ff) begin
               op_a = lo_v_ff ? lo_ff : min_ff;
               op_b = min_ff;
            end else begin
               op_a = max_ff;
               op_b = hi_v_ff ? hi_ff : max_ff;
            end
         end
         default: begin
         end
      endcase
      diff = TW'(op_a - op_b);
   end

   assign rem_sh  = {rem_ff[CW-1:0], quo_ff[DW-1]};
   assign rem_sub = rem_sh - (CW+1)'(cnt_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      kcnt_in      = kcnt_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      head_in      = head_ff;
      up_in        = up_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_v_in      = lo_v_ff;
      hi_v_in      = hi_v_ff;
      eq_in        = eq_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HEAD_POSITION: head_in = T'(csr_wdata);
            CSR_DIRECTION_UP:  up_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (keep) begin
                  cnt_in = cnt_ff + 1'b1;
                  min_in = (first || trk < min_ff) ? trk : min_ff;
                  max_in = (first || trk > max_ff) ? trk : max_ff;
                  if (trk < head_ff && (!lo_v_ff || trk > lo_ff)) begin
                     lo_in   = trk;
                     lo_v_in = 1'b1;
                  end
                  if (trk > head_ff && (!hi_v_ff || trk < hi_ff)) begin
                     hi_in   = trk;
                     hi_v_in = 1'b1;
                  end
                  if (trk == head_ff) eq_in = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  state_in = S_SUM;
                  step_in  = 2'd0;
                  acc_in   = '0;
               end
            end
         end
         S_SUM: begin
            acc_in  = (step_ff == 2'd0) ? diff : acc_ff + diff;
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd2) begin
               state_in = S_DIV;
               kcnt_in  = '0;
               quo_in   = {acc_ff + diff, 8'b0};
               rem_in   = '0;
            end
         end
         S_DIV: begin
            if (!rem_sub[CW]) begin
               rem_in = rem_sub;
            end else begin
               rem_in = rem_sh;
            end
            quo_in  = {quo_ff[DW-2:0], !rem_sub[CW]};
            kcnt_in = kcnt_ff + 1'b1;
            if (kcnt_ff == KW'(DW - 1)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.total_movement = (32'(acc_ff) > 32'(TOTAL_MAX)) ?
                                       14'(TOTAL_MAX) : 14'(acc_ff);
               rsp_in.request_count  = (32'(cnt_ff) > 32'(COUNT_MAX)) ?
                                       7'(COUNT_MAX) : 7'(cnt_ff);
               rsp_in.average_q8     = (64'(quo_in) > 64'(AVG_MAX)) ?
                                       22'(AVG_MAX) : 22'(quo_in);
               rsp_in.status         = ovf_ff;
               cnt_in  = '0;
               ovf_in  = 1'b0;
               lo_v_in = 1'b0;
               hi_v_in = 1'b0;
               eq_in   = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         kcnt_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         up_ff        <= 1'b1;
         lo_v_ff      <= 1'b0;
         hi_v_ff      <= 1'b0;
         eq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         kcnt_ff      <= kcnt_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         head_ff      <= head_in;
         up_ff        <= up_in;
         lo_v_ff      <= lo_v_in;
         hi_v_ff      <= hi_v_in;
         eq_ff        <= eq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      min_ff <= min_in;
      max_ff <= max_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe repeated");
   a_strobe_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_DIV) else $error("strobe without division");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff != '0) else $error("division by empty list");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(MAX_REQUESTS)) else $error("request count overrun");

endmodule

### sim/cscan_head_movement_tb.sv
// ----------------------------------------------------------------------------
// cscan_head_movement_tb
// Drives track lists into the C-SCAN evaluator under changing head settings
// and checks every total, count, average and overflow flag against a model.
// ----------------------------------------------------------------------------
module cscan_head_movement_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cshm_pkg::*;

   class movement_board;
      bit [11:0] tracks[$];
      bit        dropped;
      rsp_type   pending[$];
      int        errors;
      bit [11:0] head;
      bit        dir_up;

      function void note_request(req_type r);
         bit [11:0] s[$];
         int        n, st, cnt, i;
         longint    sum, pos, avg;
         rsp_type   e;
         if (tracks.size() < MAX_REQUESTS_DEF) tracks.push_back(r.track);
         else dropped = 1;
         if (!r.last) return;
         s = tracks;
         s.sort();
         n = s.size();
         sum = 0;
         pos = head;
         if (dir_up) begin
            st = n;
            for (i = n - 1; i >= 0; i--) if (s[i] >= head) st = i;
            for (i = st; i < n; i++) begin
               sum += (s[i] > pos) ? s[i] - pos : pos - s[i];
               pos = s[i];
            end
            sum += s[n-1] - s[0];
            pos = s[0];
            for (i = 0; i < st; i++) begin
               sum += s[i] - pos;
               pos = s[i];
            end
         end else begin
            cnt = 0;
            for (i = 0; i < n; i++) if (s[i] <= head) cnt = i + 1;
            for (i = cnt; i > 0; i--) begin
               sum += pos - s[i-1];
               pos = s[i-1];
            end
            sum += s[n-1] - s[0];
            pos = s[n-1];
            for (i = n; i > cnt; i--) begin
               sum += pos - s[i-1];
               pos = s[i-1];
            end
         end
         avg = (sum << 8) / n;
         e.total_movement = 14'((sum > TOTAL_MAX) ? longint'(TOTAL_MAX) : sum);
         e.request_count  = 7'((n > COUNT_MAX) ? COUNT_MAX : n);
         e.average_q8     = 22'((avg > AVG_MAX) ? longint'(AVG_MAX) : avg);
         e.status         = dropped;
         pending.push_back(e);
         tracks.delete();
         dropped = 0;
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.total_movement !== e.total_movement) begin
            $display("%0t total exp %0d got %0d", $time, e.total_movement, a.total_movement);
            errors++;
         end
         if (a.request_count !== e.request_count) begin
            $display("%0t count exp %0d got %0d", $time, e.request_count, a.request_count);
            errors++;
         end
         if (a.average_q8 !== e.average_q8) begin
            $display("%0t average exp %0d got %0d", $time, e.average_q8, a.average_q8);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t status exp %0d got %0d", $time, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [11:0] csr_wdata = '0;

   movement_board board = new();
   int            idle_pct = 0;
   longint        cycles = 0;

   cscan_head_movement u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid) board.check_result(rsp_data);
      if (cycles > 3000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, bit [11:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_HEAD_POSITION) board.head = v;
      else board.dir_up = v[0];
   endtask

   task automatic send_request(bit [11:0] trk, bit lst);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_data <= '{track: trk, last: lst};
      do @(posedge clock); while (busy);
      board.note_request('{track: trk, last: lst});
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic send_list(int n, bit [11:0] lo, bit [11:0] hi);
      for (int i = 0; i < n; i++) send_request(12'($urandom_range(hi, lo)), i == n - 1);
   endtask

   initial begin
      int n;
      board.head = 0;
      board.dir_up = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed
      send_request(12'd0, 1);
      send_request(12'hFFF, 1);
      send_request(12'd0, 0);
      send_request(12'hFFF, 1);
      drain();
      write_csr(CSR_HEAD_POSITION, 12'hFFF);
      write_csr(CSR_DIRECTION_UP, 0);
      send_request(12'd100, 0);
      send_request(12'd4000, 1);
      drain();
      write_csr(CSR_HEAD_POSITION, 12'd0);
      send_request(12'd5, 0);
      send_request(12'd9, 1);
      drain();
      write_csr(CSR_HEAD_POSITION, 12'd2048);
      write_csr(CSR_DIRECTION_UP, 1);
      send_request(12'd2048, 0);
      send_request(12'd10, 0);
      send_request(12'd4095, 1);
      drain();
      send_list(70, 0, 4095);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 19 : ((ph == 1) ? 59 : 0);
         for (int k = 0; k < 42; k++) begin
            if (k % 6 == 0) begin
               drain();
               write_csr(CSR_HEAD_POSITION, $urandom_range(5) == 0 ?
                         ($urandom_range(1) ? 12'hFFF : 12'h000) : 12'($urandom));
               write_csr(CSR_DIRECTION_UP, 12'($urandom_range(1)));
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(66, 60) : $urandom_range(12, 1);
            if ($urandom_range(3) == 0) send_list(n, 12'd1000, 12'd1100);
            else send_list(n, 0, 4095);
         end
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

### filelist.f
rtl/cshm_pkg.sv
rtl/cscan_head_movement.sv
sim/cscan_head_movement_tb.sv
